// ===== rtl/mdioc22_pkg.sv =====
// Shared types and constants for the Clause 22 MDIO management master.
// No dependencies; imported by mdioc22_slot_gen, mdio_clause22_master and the testbench.
package mdioc22_pkg;

    // Command codes carried on func
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_READ   = 3'd1;
    localparam logic [2:0] FUNC_WRITE  = 3'd2;
    localparam logic [2:0] FUNC_PREAD  = 3'd3;
    localparam logic [2:0] FUNC_PWRITE = 3'd4;

    // Command status codes
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_BUSY   = 2'd2;

    // Kinds of bit slot
    localparam logic [1:0] SLOT_W0 = 2'd0;
    localparam logic [1:0] SLOT_W1 = 2'd1;
    localparam logic [1:0] SLOT_Z  = 2'd2;
    localparam logic [1:0] SLOT_RD = 2'd3;

    // Page select register of the PHY
    localparam logic [4:0] PAGE_REG = 5'h1f;

    // Last slot index of each frame type
    localparam logic [6:0] LAST_IDX_RD = 7'd65;
    localparam logic [6:0] LAST_IDX_WR = 7'd64;
    // First slot whose read bit is kept
    localparam logic [6:0] FIRST_DATA_IDX = 7'd48;

    typedef logic [1:0] t_kind;

    typedef struct packed {
        logic [2:0]  op;
        logic [1:0]  step;
        logic [6:0]  bidx;
        logic [4:0]  phy;
        logic [4:0]  reg_addr;
        logic [15:0] page;
        logic [15:0] wdata;
    } t_frame_ctl;

    typedef struct packed {
        t_kind kind;
        logic  is_read;
    } t_slot;

endpackage

// ===== rtl/mdioc22_slot_gen.sv =====
// Decodes the current sequence step and slot index into the kind of bit slot.
// Depends on mdioc22_pkg.
module mdioc22_slot_gen
    import mdioc22_pkg::*;
(
    input  t_frame_ctl i_ctl,
    output t_slot      o_slot
);

    logic        is_read;
    logic [4:0]  fr_reg;
    logic [15:0] fr_data;
    logic [6:0]  phy_off;
    logic [6:0]  reg_off;
    t_kind       kind;

    // frame parameters of the current step
    always_comb begin
        is_read = 1'b0;
        fr_reg  = i_ctl.reg_addr;
        fr_data = i_ctl.wdata;
        unique case (i_ctl.op)
            FUNC_READ: begin
                is_read = 1'b1;
            end
            FUNC_PREAD: begin
                if (i_ctl.step == 2'd0) begin
                    fr_reg  = PAGE_REG;
                    fr_data = i_ctl.page;
                end else if (i_ctl.step == 2'd1) begin
                    is_read = 1'b1;
                end else begin
                    fr_reg  = PAGE_REG;
                    fr_data = '0;
                end
            end
            FUNC_PWRITE: begin
                if (i_ctl.step == 2'd0) begin
                    fr_reg  = PAGE_REG;
                    fr_data = i_ctl.page;
                end else if (i_ctl.step == 2'd2) begin
                    is_read = 1'b1;
                end else if (i_ctl.step == 2'd3) begin
                    fr_reg  = PAGE_REG;
                    fr_data = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign phy_off = 7'd40 - i_ctl.bidx;
    assign reg_off = 7'd45 - i_ctl.bidx;

    always_comb begin
        logic [6:0] ix;
        ix = i_ctl.bidx;
        if (ix < 7'd32) begin
            kind = SLOT_W1;                     // preamble
        end else if (ix == 7'd32) begin
            kind = SLOT_W0;
        end else if (ix == 7'd33) begin
            kind = SLOT_W1;
        end else if (ix == 7'd34) begin
            kind = is_read ? SLOT_W1 : SLOT_W0;
        end else if (ix == 7'd35) begin
            kind = is_read ? SLOT_W0 : SLOT_W1;
        end else if (ix <= 7'd40) begin
            kind = i_ctl.phy[phy_off[2:0]] ? SLOT_W1 : SLOT_W0;
        end else if (ix <= 7'd45) begin
            kind = fr_reg[reg_off[2:0]] ? SLOT_W1 : SLOT_W0;
        end else if (is_read) begin
            if (ix == 7'd46) begin
                kind = SLOT_Z;                  // turnaround, no clock edge
            end else if (ix <= 7'd63) begin
                kind = SLOT_RD;
            end else if (ix == 7'd64) begin
                kind = SLOT_W1;
            end else begin
                kind = SLOT_Z;
            end
        end else begin
            if (ix == 7'd46) begin
                kind = SLOT_W1;
            end else if (ix == 7'd47) begin
                kind = SLOT_W0;
            end else if (ix <= 7'd63) begin
                // slots 48..63 carry data bit 15 down to 0
                kind = fr_data[~ix[3:0]] ? SLOT_W1 : SLOT_W0;
            end else begin
                kind = SLOT_Z;
            end
        end
    end

    assign o_slot.kind    = kind;
    assign o_slot.is_read = is_read;

endmodule

// ===== rtl/mdio_clause22_master.sv =====
// Top level of the Clause 22 MDIO management master: sequencer, pin state
// and result register. Depends on mdioc22_pkg and mdioc22_slot_gen.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall | func, phy/reg addr, page, data, mdio
//  out     | output    | o_out_valid/i_out_stall | mdc, mdio, oe, busy, done, rd, status
//  cfg     | input     | i_cfg_we                | half_period_ticks
//
// One item in, one result out; an item is taken every unstalled cycle, its result shown
// on the next cycle from the output register. The tick counter, slot index and
// step are updated with a single pass of logic per item. Synchronous active-low
// reset puts the half period at 10 and the pins at mdc 0, mdio 0, driven.
// A stalled result stalls the input only while the output register is full.
module mdio_clause22_master
    import mdioc22_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [4:0]  i_phy_addr,
    input  logic [4:0]  i_reg_addr,
    input  logic [15:0] i_page_sel,
    input  logic [15:0] i_wr_data,
    input  logic        i_mdio_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_mdc,
    output logic        o_mdio_out,
    output logic        o_mdio_oe,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [15:0] o_rd_data,
    output logic [1:0]  o_cmd_status,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_data
);

    // sequencer state
    logic [9:0]  r_half, n_half;
    logic [2:0]  r_op, n_op;
    logic [1:0]  r_step, n_step;
    logic [6:0]  r_bidx, n_bidx;
    logic        r_phase, n_phase;
    logic [9:0]  r_tc, n_tc;
    logic [4:0]  r_phy, n_phy;
    logic [4:0]  r_reg, n_reg;
    logic [15:0] r_page, n_page;
    logic [15:0] r_wdata, n_wdata;
    logic [15:0] r_rx, n_rx;
    logic        r_mdc, n_mdc;
    logic        r_mdio, n_mdio;
    logic        r_oe, n_oe;

    // result register
    logic        r_out_valid, n_out_valid;
    logic        r_o_busy, r_o_done;
    logic [15:0] r_o_rd;
    logic [1:0]  r_o_status;

    logic        accept;
    logic        start;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [15:0] rd_val;
    logic [2:0]  op;
    logic [1:0]  step;
    logic [6:0]  bidx;
    logic        phase;
    logic [9:0]  tc;
    logic [15:0] rx;
    logic [9:0]  hp;
    logic [10:0] tc_inc;
    logic        last_step;
    t_frame_ctl  ctl;
    t_slot       slot;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign start  = (i_func >= FUNC_READ) && (i_func <= FUNC_PWRITE) && (r_op == FUNC_TICK);
    assign status = ((i_func >= FUNC_READ) && (i_func <= FUNC_PWRITE))
                    ? ((r_op == FUNC_TICK) ? ST_ACCEPT : ST_BUSY) : ST_NONE;

    // state as seen by this item, after a possible command start
    assign op    = start ? i_func : r_op;
    assign step  = start ? 2'd0 : r_step;
    assign bidx  = start ? 7'd0 : r_bidx;
    assign phase = start ? 1'b0 : r_phase;
    assign tc    = start ? 10'd0 : r_tc;
    assign rx    = start ? 16'd0 : r_rx;

    assign ctl.op       = op;
    assign ctl.step     = step;
    assign ctl.bidx     = bidx;
    assign ctl.phy      = start ? i_phy_addr : r_phy;
    assign ctl.reg_addr = start ? i_reg_addr : r_reg;
    assign ctl.page     = start ? i_page_sel : r_page;
    assign ctl.wdata    = start ? i_wr_data  : r_wdata;

    mdioc22_slot_gen u_slot (
        .i_ctl  (ctl),
        .o_slot (slot)
    );

    assign hp     = (r_half == 10'd0) ? 10'd1 : r_half;
    assign tc_inc = {1'b0, tc} + 11'd1;

    always_comb begin
        unique case (op)
            FUNC_PREAD:  last_step = (step == 2'd2);
            FUNC_PWRITE: last_step = (step == 2'd3);
            default:     last_step = 1'b1;
        endcase
    end

    always_comb begin
        n_op    = r_op;
        n_step  = r_step;
        n_bidx  = r_bidx;
        n_phase = r_phase;
        n_tc    = r_tc;
        n_phy   = ctl.phy;
        n_reg   = ctl.reg_addr;
        n_page  = ctl.page;
        n_wdata = ctl.wdata;
        n_rx    = rx;
        n_mdc   = r_mdc;
        n_mdio  = r_mdio;
        n_oe    = r_oe;
        busy    = 1'b0;
        done    = 1'b0;
        rd_val  = '0;
        if (op != FUNC_TICK) begin
            busy    = 1'b1;
            n_op    = op;
            n_step  = step;
            n_bidx  = bidx;
            n_phase = phase;
            case (slot.kind) inside
                SLOT_W0, SLOT_W1: begin
                    n_mdio = (slot.kind == SLOT_W1);
                    n_oe   = 1'b1;
                    n_mdc  = phase;
                end
                SLOT_Z: begin
                    n_mdio = 1'b0;
                    n_mdc  = 1'b0;
                end
                default: begin
                    n_oe  = 1'b0;
                    n_mdc = ~phase;
                end
            endcase
            if (tc_inc >= {1'b0, hp}) begin
                n_tc = '0;
                if (!phase) begin
                    n_phase = 1'b1;
                end else begin
                    n_phase = 1'b0;
                    if (slot.kind == SLOT_RD && bidx >= FIRST_DATA_IDX) begin
                        n_rx = {rx[14:0], i_mdio_in};
                    end
                    if (bidx == (slot.is_read ? LAST_IDX_RD : LAST_IDX_WR)) begin
                        n_bidx = '0;
                        n_step = step + 2'd1;
                        if (last_step) begin
                            done   = 1'b1;
                            rd_val = n_rx;
                            n_op   = FUNC_TICK;
                            n_step = '0;
                        end
                    end else begin
                        n_bidx = bidx + 7'd1;
                    end
                end
            end else begin
                n_tc = tc_inc[9:0];
            end
        end
    end

    assign n_half      = i_cfg_we ? i_cfg_data : r_half;
    assign n_out_valid = accept ? 1'b1 : (i_out_stall & r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= 10'd10;
            r_op        <= FUNC_TICK;
            r_step      <= '0;
            r_bidx      <= '0;
            r_phase     <= 1'b0;
            r_tc        <= '0;
            r_phy       <= '0;
            r_reg       <= '0;
            r_page      <= '0;
            r_wdata     <= '0;
            r_rx        <= '0;
            r_mdc       <= 1'b0;
            r_mdio      <= 1'b0;
            r_oe        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_op    <= n_op;
                r_step  <= n_step;
                r_bidx  <= n_bidx;
                r_phase <= n_phase;
                r_tc    <= n_tc;
                r_phy   <= n_phy;
                r_reg   <= n_reg;
                r_page  <= n_page;
                r_wdata <= n_wdata;
                r_rx    <= n_rx;
                r_mdc   <= n_mdc;
                r_mdio  <= n_mdio;
                r_oe    <= n_oe;
            end
        end
    end

    // result payload, loaded with each item
    logic r_o_mdc, r_o_mdio, r_o_oe;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_o_mdc    <= n_mdc;
            r_o_mdio   <= n_mdio;
            r_o_oe     <= n_oe;
            r_o_busy   <= busy;
            r_o_done   <= done;
            r_o_rd     <= rd_val;
            r_o_status <= status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mdc        = r_o_mdc;
    assign o_mdio_out   = r_o_mdio;
    assign o_mdio_oe    = r_o_oe;
    assign o_busy_res   = r_o_busy;
    assign o_done_res   = r_o_done;
    assign o_rd_data    = r_o_rd;
    assign o_cmd_status = r_o_status;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_done_res |-> o_rd_data == 16'd0)
        else $error("read data set without done");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && start |=> r_op != FUNC_TICK)
        else $error("accepted command did not start a sequence");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op == FUNC_TICK |-> r_bidx == 7'd0 && r_step == 2'd0)
        else $error("slot index or step left over when idle");

    a_bidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bidx <= LAST_IDX_RD)
        else $error("slot index past end of frame");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for mdio_clause22_master: streams of ticks and MDIO commands are
// checked result by result against an in-bench model of the frame sequencer.
// Depends on mdioc22_pkg and the mdio_clause22_master RTL.
module testbench;
    import mdioc22_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 80;

    // func codes the block does not define; they must act as plain ticks
    localparam logic [2:0] FUNC_UNDEF_FIRST = 3'd5;
    localparam logic [2:0] FUNC_UNDEF_LAST  = 3'd7;

    // level seen on the MDIO pin during a stream of ticks
    localparam int MDIO_ZEROS  = 0;
    localparam int MDIO_ONES   = 1;
    localparam int MDIO_RANDOM = 2;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  phy;
        logic [4:0]  regad;
        logic [15:0] page;
        logic [15:0] wdata;
        logic        mdio;
    } t_tick_item;

    typedef struct packed {
        logic        mdc;
        logic        mdio_out;
        logic        mdio_oe;
        logic        busy;
        logic        done;
        logic [15:0] rd;
        logic [1:0]  status;
    } t_pin_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_func = FUNC_TICK;
    logic [4:0]  i_phy_addr = '0;
    logic [4:0]  i_reg_addr = '0;
    logic [15:0] i_page_sel = '0;
    logic [15:0] i_wr_data = '0;
    logic        i_mdio_in = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [9:0]  i_cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_mdc;
    logic        o_mdio_out;
    logic        o_mdio_oe;
    logic        o_busy_res;
    logic        o_done_res;
    logic [15:0] o_rd_data;
    logic [1:0]  o_cmd_status;

    mdio_clause22_master dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_phy_addr   (i_phy_addr),
        .i_reg_addr   (i_reg_addr),
        .i_page_sel   (i_page_sel),
        .i_wr_data    (i_wr_data),
        .i_mdio_in    (i_mdio_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mdc        (o_mdc),
        .o_mdio_out   (o_mdio_out),
        .o_mdio_oe    (o_mdio_oe),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rd_data    (o_rd_data),
        .o_cmd_status (o_cmd_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // bench bookkeeping
    t_tick_item tick_queue[$];
    t_pin_state expected_pins[$];
    int         items_issued = 0;
    int         items_taken = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    int         hold_left = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    logic       in_fire = 1'b0;
    logic       quiet = 1'b0;

    // model state of the master
    logic [9:0]  hp_cfg = 10'd10;
    logic [2:0]  m_op = FUNC_TICK;
    logic [1:0]  m_step = '0;
    logic [6:0]  m_bit = '0;
    logic        m_half = 1'b0;
    logic [9:0]  m_cnt = '0;
    logic [4:0]  m_phy = '0;
    logic [4:0]  m_reg = '0;
    logic [15:0] m_page = '0;
    logic [15:0] m_wdata = '0;
    logic [15:0] m_rx = '0;
    logic        pin_mdc = 1'b0;
    logic        pin_mdio = 1'b0;
    logic        pin_oe = 1'b1;
    int          done_by_op [5] = '{default: 0};
    int          seq_done = 0;
    int          rejected = 0;

    function automatic t_kind slot_of(logic rd_frame, logic [4:0] ra, logic [15:0] d,
                                      logic [6:0] idx);
        if (idx < 7'd32) return SLOT_W1;
        if (idx == 7'd32) return SLOT_W0;
        if (idx == 7'd33) return SLOT_W1;
        if (idx == 7'd34) return rd_frame ? SLOT_W1 : SLOT_W0;
        if (idx == 7'd35) return rd_frame ? SLOT_W0 : SLOT_W1;
        if (idx <= 7'd40) return m_phy[3'(7'd40 - idx)] ? SLOT_W1 : SLOT_W0;
        if (idx <= 7'd45) return ra[3'(7'd45 - idx)] ? SLOT_W1 : SLOT_W0;
        if (rd_frame) begin
            if (idx == 7'd46) return SLOT_Z;
            if (idx <= 7'd63) return SLOT_RD;
            if (idx == 7'd64) return SLOT_W1;
            return SLOT_Z;
        end
        if (idx == 7'd46) return SLOT_W1;
        if (idx == 7'd47) return SLOT_W0;
        if (idx <= 7'd63) return d[4'(7'd63 - idx)] ? SLOT_W1 : SLOT_W0;
        return SLOT_Z;
    endfunction

    // Advances the master by one tick and gives the pin/status levels it shows.
    task automatic mdio_master_tick(input t_tick_item it, output t_pin_state r);
        logic        rd_frame;
        logic [4:0]  ra;
        logic [15:0] d;
        t_kind       k;
        logic [10:0] tc;
        logic [10:0] hp;
        int          steps;
        r = '0;
        if (it.func >= FUNC_READ && it.func <= FUNC_PWRITE) begin
            if (m_op != FUNC_TICK) begin
                r.status = ST_BUSY;
                rejected++;
            end else begin
                r.status = ST_ACCEPT;
                m_op = it.func;
                m_step = '0;
                m_bit = '0;
                m_half = 1'b0;
                m_cnt = '0;
                m_phy = it.phy;
                m_reg = it.regad;
                m_page = it.page;
                m_wdata = it.wdata;
                m_rx = '0;
            end
        end
        if (m_op != FUNC_TICK) begin
            r.busy = 1'b1;
            rd_frame = 1'b0;
            ra = m_reg;
            d = m_wdata;
            steps = 1;
            case (m_op)
                FUNC_READ: begin
                    rd_frame = 1'b1;
                end
                FUNC_PREAD: begin
                    steps = 3;
                    if (m_step == 2'd0) begin
                        ra = PAGE_REG;
                        d = m_page;
                    end else if (m_step == 2'd1) begin
                        rd_frame = 1'b1;
                    end else begin
                        ra = PAGE_REG;
                        d = '0;
                    end
                end
                FUNC_PWRITE: begin
                    steps = 4;
                    if (m_step == 2'd0) begin
                        ra = PAGE_REG;
                        d = m_page;
                    end else if (m_step == 2'd2) begin
                        rd_frame = 1'b1;
                    end else if (m_step == 2'd3) begin
                        ra = PAGE_REG;
                        d = '0;
                    end
                end
                default: ;
            endcase
            k = slot_of(rd_frame, ra, d, m_bit);
            if (k == SLOT_W0 || k == SLOT_W1) begin
                pin_mdio = (k == SLOT_W1);
                pin_oe = 1'b1;
                pin_mdc = m_half;
            end else if (k == SLOT_Z) begin
                // oe deliberately left as it was
                pin_mdio = 1'b0;
                pin_mdc = 1'b0;
            end else begin
                pin_oe = 1'b0;
                pin_mdc = ~m_half;
            end
            hp = (hp_cfg == '0) ? 11'd1 : {1'b0, hp_cfg};
            tc = {1'b0, m_cnt} + 11'd1;
            if (tc >= hp) begin
                m_cnt = '0;
                if (!m_half) begin
                    m_half = 1'b1;
                end else begin
                    m_half = 1'b0;
                    if (k == SLOT_RD && m_bit >= FIRST_DATA_IDX)
                        m_rx = {m_rx[14:0], it.mdio};
                    if (m_bit == (rd_frame ? LAST_IDX_RD : LAST_IDX_WR)) begin
                        m_bit = '0;
                        if (int'(m_step) + 1 >= steps) begin
                            r.done = 1'b1;
                            r.rd = m_rx;
                            done_by_op[m_op]++;
                            seq_done++;
                            m_op = FUNC_TICK;
                            m_step = '0;
                        end else begin
                            m_step = m_step + 2'd1;
                        end
                    end else begin
                        m_bit = m_bit + 7'd1;
                    end
                end
            end else begin
                m_cnt = tc[9:0];
            end
        end
        r.mdc = pin_mdc;
        r.mdio_out = pin_mdio;
        r.mdio_oe = pin_oe;
    endtask

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Sample on the rising edge: predict accepted items, check accepted results.
    always @(posedge i_clk) begin : watch_pins
        t_tick_item it;
        t_pin_state want;
        t_pin_state got;
        cycle_count++;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            it = '{i_func, i_phy_addr, i_reg_addr, i_page_sel, i_wr_data, i_mdio_in};
            mdio_master_tick(it, want);
            expected_pins.push_back(want);
            items_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_mdc, o_mdio_out, o_mdio_oe, o_busy_res, o_done_res, o_rd_data,
                    o_cmd_status};
            if (expected_pins.size() == 0) begin
                $error("result item with no input item outstanding");
                fail_count++;
            end else begin
                want = expected_pins.pop_front();
                check_field("mdc", 16'(want.mdc), 16'(got.mdc));
                check_field("mdio_out", 16'(want.mdio_out), 16'(got.mdio_out));
                check_field("mdio_oe", 16'(want.mdio_oe), 16'(got.mdio_oe));
                check_field("busy_res", 16'(want.busy), 16'(got.busy));
                check_field("done_res", 16'(want.done), 16'(got.done));
                check_field("rd_data", want.rd, got.rd);
                check_field("cmd_status", 16'(want.status), 16'(got.status));
            end
        end
    end

    // Sender: new item once the current one is taken, with random gaps.
    always @(negedge i_clk) begin : drive_ticks
        t_tick_item nxt;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (tick_queue.size() > 0) begin
                nxt = tick_queue.pop_front();
                i_in_valid <= 1'b1;
                i_func <= nxt.func;
                i_phy_addr <= nxt.phy;
                i_reg_addr <= nxt.regad;
                i_page_sel <= nxt.page;
                i_wr_data <= nxt.wdata;
                i_mdio_in <= nxt.mdio;
                if (!quiet && $urandom_range(0, 11) == 0)
                    send_gap <= $urandom_range(1, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: short random stalls, plus one long hold-off on request.
    always @(negedge i_clk) begin : drive_stall
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic logic mdio_level(int mode);
        if (mode == MDIO_ZEROS) return 1'b0;
        if (mode == MDIO_ONES) return 1'b1;
        return 1'($urandom);
    endfunction

    // ticks a whole command sequence lasts
    function automatic int seq_ticks(logic [2:0] f, logic [9:0] hp);
        int slots;
        case (f)
            FUNC_READ:   slots = 66;
            FUNC_WRITE:  slots = 65;
            FUNC_PREAD:  slots = 65 + 66 + 65;
            FUNC_PWRITE: slots = 65 + 65 + 66 + 65;
            default:     slots = 0;
        endcase
        return slots * 2 * ((hp == '0) ? 1 : int'(hp));
    endfunction

    task automatic queue_item(input logic [2:0] f, input logic [4:0] pa, input logic [4:0] ra,
                              input logic [15:0] pg, input logic [15:0] wd, input logic md);
        t_tick_item it;
        it = '{f, pa, ra, pg, wd, md};
        tick_queue.push_back(it);
        items_issued++;
    endtask

    // plain ticks, with an occasional stray command mixed in
    task automatic queue_ticks(input int n, input int mode, input int noise);
        logic [2:0] f;
        for (int i = 0; i < n; i++) begin
            f = FUNC_TICK;
            if ($urandom_range(0, 99) < noise)
                f = 3'($urandom_range(FUNC_READ, FUNC_UNDEF_LAST));
            queue_item(f, 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                       mdio_level(mode));
        end
    endtask

    task automatic run_cmd(input logic [2:0] f, input logic [4:0] pa, input logic [4:0] ra,
                           input logic [15:0] pg, input logic [15:0] wd,
                           input int mode, input int noise, input int slack);
        queue_item(f, pa, ra, pg, wd, mdio_level(mode));
        queue_ticks(seq_ticks(f, hp_cfg) - 1 + slack, mode, noise);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (items_taken != items_issued || expected_pins.size() != 0);
    endtask

    task automatic set_half_period(input logic [9:0] v);
        wait_idle();
        repeat (2) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        hp_cfg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : watchdog
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles, %0d items still expected", cycle_count,
                 expected_pins.size());
        $display("mdio_clause22_master verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // paged write begun at the reset half period, raised to the longest
        // part way through a half slot, then lowered so that half ends at once
        queue_item(FUNC_PWRITE, 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                   1'b0);
        queue_ticks(20, MDIO_RANDOM, 0);
        set_half_period(10'h3FF);
        queue_ticks(10, MDIO_RANDOM, 0);
        set_half_period(10'd1);
        queue_ticks(seq_ticks(FUNC_PWRITE, 10'd1) + 2, MDIO_RANDOM, 0);
        // long receiver hold-off while items keep coming
        @(posedge i_clk);
        hold_requests++;

        // undefined codes while idle
        queue_item(FUNC_UNDEF_FIRST, 5'd1, 5'd2, 16'h1111, 16'h2222, 1'b1);
        queue_item(FUNC_UNDEF_FIRST + 3'd1, 5'd3, 5'd4, 16'h3333, 16'h4444, 1'b0);
        queue_item(FUNC_UNDEF_LAST, 5'd5, 5'd6, 16'h5555, 16'h6666, 1'b1);
        // plain read, with commands and an undefined code arriving while busy
        queue_item(FUNC_READ, 5'h11, 5'h02, 16'h0000, 16'h0000, 1'b1);
        queue_item(FUNC_READ, 5'h11, 5'h02, 16'h0000, 16'h0000, 1'b1);
        queue_item(FUNC_WRITE, 5'h12, 5'h03, 16'h0000, 16'hBEEF, 1'b0);
        queue_item(FUNC_PWRITE, 5'h13, 5'h04, 16'h0F0F, 16'hF0F0, 1'b1);
        queue_item(FUNC_PREAD, 5'h14, 5'h05, 16'h00FF, 16'hFF00, 1'b0);
        queue_item(FUNC_UNDEF_LAST, 5'h15, 5'h06, 16'h0000, 16'h0000, 1'b1);
        queue_ticks(seq_ticks(FUNC_READ, 10'd1) - 4, MDIO_RANDOM, 0);

        // closing stretch without any idling; a zero half period acts as one
        quiet = 1'b1;
        set_half_period(10'd0);
        run_cmd(FUNC_PREAD, 5'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
                MDIO_RANDOM, 0, 2);
        wait_idle();
        repeat (8) @(negedge i_clk);

        $display("%0d ticks, %0d sequences done (read %0d, paged read %0d, paged write %0d)",
                 items_taken, seq_done, done_by_op[FUNC_READ], done_by_op[FUNC_PREAD],
                 done_by_op[FUNC_PWRITE]);
        $display("%0d commands refused while busy; half periods 10, 1023, 1 and 0",
                 rejected);
        if (fail_count == 0)
            $display("mdio_clause22_master verification clean");
        else
            $display("mdio_clause22_master verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mdioc22_pkg.sv
rtl/mdioc22_slot_gen.sv
rtl/mdio_clause22_master.sv
sim/testbench.sv
